// ===== sv/context_tagged_tlb_macros.svh =====
// Assertion macros used by the translation buffer top level.
`ifndef CONTEXT_TAGGED_TLB_MACROS_SVH
`define CONTEXT_TAGGED_TLB_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CTT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/ctt_pkg.sv =====
// Package with types, constants and helper functions of the translation buffer.
package ctt_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int CTX_W = 8;
    localparam int VA_W  = 32;
    localparam int LVL_W = 2;
    localparam int PTE_W = 32;

    localparam logic [VA_W-1:0] MASK_LEVEL_4K   = 32'hffff_f000;
    localparam logic [VA_W-1:0] MASK_LEVEL_256K = 32'hfffc_0000;
    localparam logic [VA_W-1:0] MASK_LEVEL_16M  = 32'hff00_0000;
    localparam logic [VA_W-1:0] MASK_LEVEL_ALL  = 32'h0000_0000;

    localparam logic [1:0] PTE_TYPE_MASK  = 2'h3;
    localparam logic [1:0] PTE_TYPE_VALID = 2'h2;

    typedef enum logic [1:0] {
        OP_LOOKUP     = 2'd0,
        OP_INSERT     = 2'd1,
        OP_INVALIDATE = 2'd2,
        OP_FLUSH      = 2'd3
    } opcode_t;

    typedef enum logic [LVL_W-1:0] {
        LVL_ALL  = 2'd0,
        LVL_16M  = 2'd1,
        LVL_256K = 2'd2,
        LVL_4K   = 2'd3
    } level_code_t;

    // One item as it leaves the input register, with its commit strobe.
    typedef struct packed {
        logic             fire;
        opcode_t          op;
        logic [CTX_W-1:0] ctx;
        logic [VA_W-1:0]  va;
        logic [LVL_W-1:0] lvl;
        logic [PTE_W-1:0] pte;
    } req_t;

    // Match result of the slot array or the recent register.
    typedef struct packed {
        logic             hit;
        logic [CTX_W-1:0] ctx;
        logic [VA_W-1:0]  tag;
        logic [LVL_W-1:0] lvl;
        logic [PTE_W-1:0] pte;
    } match_t;

    function automatic logic [VA_W-1:0] level_mask(input logic [LVL_W-1:0] lvl);
        logic [VA_W-1:0] m;
        case (level_code_t'(lvl))
            LVL_4K:   m = MASK_LEVEL_4K;
            LVL_256K: m = MASK_LEVEL_256K;
            LVL_16M:  m = MASK_LEVEL_16M;
            default:  m = MASK_LEVEL_ALL;
        endcase
        return m;
    endfunction

    function automatic logic entry_ok(input logic [PTE_W-1:0] pte);
        return (pte[1:0] & PTE_TYPE_MASK) == PTE_TYPE_VALID;
    endfunction

endpackage

// ===== sv/ctt_slots.sv =====
// Slot array: parallel tag compare, priority pick, FIFO replacement, invalidate, flush.
module ctt_slots (
    input  logic            aclk,
    input  logic            aresetn,
    input  ctt_pkg::req_t   req,
    output ctt_pkg::match_t slot_match
);

    logic [ctt_pkg::CTX_W-1:0]      ctx_reg [ctt_pkg::NUM_SLOTS];
    logic [ctt_pkg::VA_W-1:0]       tag_reg [ctt_pkg::NUM_SLOTS];
    logic [ctt_pkg::LVL_W-1:0]      lvl_reg [ctt_pkg::NUM_SLOTS];
    logic [ctt_pkg::PTE_W-1:0]      pte_reg [ctt_pkg::NUM_SLOTS];
    logic [ctt_pkg::SLOT_IDX_W-1:0] victim_reg;
    logic [ctt_pkg::SLOT_IDX_W-1:0] victim_next;
    logic [ctt_pkg::NUM_SLOTS-1:0]  match_vec;
    logic                           insert_ok;
    logic [ctt_pkg::VA_W-1:0]       insert_tag;

    // Compare every slot against the request in parallel.
    always_comb begin
        for (int i = 0; i < ctt_pkg::NUM_SLOTS; i++) begin
            match_vec[i] = ctt_pkg::entry_ok(pte_reg[i]) && (ctx_reg[i] == req.ctx) &&
                           ((req.va & ctt_pkg::level_mask(lvl_reg[i])) == tag_reg[i]);
        end
    end

    // Pick the lowest-index matching slot.
    always_comb begin
        slot_match = '0;
        for (int i = ctt_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                slot_match.hit = 1'b1;
                slot_match.ctx = ctx_reg[i];
                slot_match.tag = tag_reg[i];
                slot_match.lvl = lvl_reg[i];
                slot_match.pte = pte_reg[i];
            end
        end
    end

    assign insert_ok   = req.fire && (req.op == ctt_pkg::OP_INSERT) && ctt_pkg::entry_ok(req.pte);
    assign insert_tag  = req.va & ctt_pkg::level_mask(req.lvl);
    assign victim_next = (victim_reg == ctt_pkg::SLOT_IDX_W'(ctt_pkg::NUM_SLOTS - 1)) ?
                         '0 : victim_reg + 1'b1;

    // Entry words and victim pointer: the entry word carries the valid code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ctt_pkg::NUM_SLOTS; i++) begin
                pte_reg[i] <= '0;
            end
            victim_reg <= '0;
        end else if (req.fire) begin
            case (req.op)
                ctt_pkg::OP_INSERT: begin
                    if (insert_ok) begin
                        for (int i = 0; i < ctt_pkg::NUM_SLOTS; i++) begin
                            if (victim_reg == ctt_pkg::SLOT_IDX_W'(i)) begin
                                pte_reg[i] <= req.pte;
                            end
                        end
                        victim_reg <= victim_next;
                    end
                end
                ctt_pkg::OP_INVALIDATE: begin
                    for (int i = 0; i < ctt_pkg::NUM_SLOTS; i++) begin
                        if (match_vec[i]) begin
                            pte_reg[i] <= '0;
                        end
                    end
                end
                ctt_pkg::OP_FLUSH: begin
                    for (int i = 0; i < ctt_pkg::NUM_SLOTS; i++) begin
                        pte_reg[i] <= '0;
                    end
                    victim_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Slot payload: only read behind a valid entry word, so no reset.
    always_ff @(posedge aclk) begin
        if (insert_ok) begin
            for (int i = 0; i < ctt_pkg::NUM_SLOTS; i++) begin
                if (victim_reg == ctt_pkg::SLOT_IDX_W'(i)) begin
                    ctx_reg[i] <= req.ctx;
                    tag_reg[i] <= insert_tag;
                    lvl_reg[i] <= req.lvl;
                end
            end
        end
    end

endmodule

// ===== sv/ctt_recent.sv =====
// Most-recent translation register in front of the slot array.
module ctt_recent (
    input  logic            aclk,
    input  logic            aresetn,
    input  ctt_pkg::req_t   req,
    input  ctt_pkg::match_t slot_match,
    output ctt_pkg::match_t recent_match
);

    logic                      valid_reg;
    logic [ctt_pkg::CTX_W-1:0] ctx_reg;
    logic [ctt_pkg::VA_W-1:0]  tag_reg;
    logic [ctt_pkg::LVL_W-1:0] lvl_reg;
    logic [ctt_pkg::PTE_W-1:0] pte_reg;
    logic                      load_slot;
    logic                      load_insert;

    // Compare the request against the held translation.
    always_comb begin
        recent_match.hit = valid_reg && (ctx_reg == req.ctx) &&
                           ((req.va & ctt_pkg::level_mask(lvl_reg)) == tag_reg);
        recent_match.ctx = ctx_reg;
        recent_match.tag = tag_reg;
        recent_match.lvl = lvl_reg;
        recent_match.pte = pte_reg;
    end

    assign load_slot   = req.fire && (req.op == ctt_pkg::OP_LOOKUP) &&
                         !recent_match.hit && slot_match.hit;
    assign load_insert = req.fire && (req.op == ctt_pkg::OP_INSERT) &&
                         ctt_pkg::entry_ok(req.pte);

    // Valid flag: set on reload or insert, drop on invalidate or flush.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ctx_reg   <= '0;
            tag_reg   <= '0;
            lvl_reg   <= '0;
            pte_reg   <= '0;
        end else if (load_slot) begin
            valid_reg <= 1'b1;
            ctx_reg   <= slot_match.ctx;
            tag_reg   <= slot_match.tag;
            lvl_reg   <= slot_match.lvl;
            pte_reg   <= slot_match.pte;
        end else if (load_insert) begin
            valid_reg <= 1'b1;
            ctx_reg   <= req.ctx;
            tag_reg   <= req.va & ctt_pkg::level_mask(req.lvl);
            lvl_reg   <= req.lvl;
            pte_reg   <= req.pte;
        end else if (req.fire && ((req.op == ctt_pkg::OP_INVALIDATE) ||
                                  (req.op == ctt_pkg::OP_FLUSH))) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/context_tagged_tlb.sv =====
// Top level of the context-tagged translation buffer.
// Usage:
//   Input channel s_*: one command item per handshake (lookup, insert,
//   invalidate by context and address, flush all) with its operands.
//   Result channel m_*: exactly one result item per command item, in order;
//   hit, found_entry and found_level are zero for anything but a lookup hit.
//   Flow: an accepted item is held in the input register, resolved
//   against all slots and the recent register in parallel, and shown on
//   m_* from the result register once it moves there. Throughput: one
//   item per cycle while m_ready stays high; the slot compare and priority
//   pick sit in one stage between input and result registers.
//   State is updated when an item moves from the input register into the
//   result register, so later items see the effect of earlier ones.
//   Reset: all slots invalid, victim pointer zero, recent register empty,
//   both registers empty; s_ready is high in the first cycle after reset.
//   Stall: while m_ready is low the result holds and one more item waits
//   in the input register; s_ready drops only when both are full.
`include "context_tagged_tlb_macros.svh"

module context_tagged_tlb (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_opcode,
    input  logic [ctt_pkg::CTX_W-1:0]  s_context_req,
    input  logic [ctt_pkg::VA_W-1:0]   s_virtual_address,
    input  logic [ctt_pkg::LVL_W-1:0]  s_page_level,
    input  logic [ctt_pkg::PTE_W-1:0]  s_table_entry,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output logic [ctt_pkg::PTE_W-1:0]  m_found_entry,
    output logic [ctt_pkg::LVL_W-1:0]  m_found_level
);

    logic                      in_valid_reg;
    ctt_pkg::opcode_t          op_reg;
    logic [ctt_pkg::CTX_W-1:0] ctx_reg;
    logic [ctt_pkg::VA_W-1:0]  va_reg;
    logic [ctt_pkg::LVL_W-1:0] lvl_reg;
    logic [ctt_pkg::PTE_W-1:0] pte_reg;
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [ctt_pkg::PTE_W-1:0] entry_reg;
    logic [ctt_pkg::LVL_W-1:0] level_reg;
    logic                      hit_next;
    logic [ctt_pkg::PTE_W-1:0] entry_next;
    logic [ctt_pkg::LVL_W-1:0] level_next;
    logic                      advance;
    ctt_pkg::req_t             req;
    ctt_pkg::match_t           slot_match;
    ctt_pkg::match_t           recent_match;

    // Move the held item into the result register when that is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= ctt_pkg::opcode_t'(s_opcode);
            ctx_reg <= s_context_req;
            va_reg  <= s_virtual_address;
            lvl_reg <= s_page_level;
            pte_reg <= s_table_entry;
        end
    end

    assign req.fire = advance;
    assign req.op   = op_reg;
    assign req.ctx  = ctx_reg;
    assign req.va   = va_reg;
    assign req.lvl  = lvl_reg;
    assign req.pte  = pte_reg;

    ctt_slots u_slots (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .slot_match (slot_match)
    );

    ctt_recent u_recent (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (req),
        .slot_match   (slot_match),
        .recent_match (recent_match)
    );

    // Choose the answer: recent register first, then the slot array.
    always_comb begin
        hit_next   = 1'b0;
        entry_next = '0;
        level_next = '0;
        if (op_reg == ctt_pkg::OP_LOOKUP) begin
            if (recent_match.hit) begin
                hit_next   = 1'b1;
                entry_next = recent_match.pte;
                level_next = recent_match.lvl;
            end else if (slot_match.hit) begin
                hit_next   = 1'b1;
                entry_next = slot_match.pte;
                level_next = slot_match.lvl;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_reg   <= hit_next;
            entry_reg <= entry_next;
            level_reg <= level_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_hit         = hit_reg;
    assign m_found_entry = entry_reg;
    assign m_found_level = level_reg;

    `CTT_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid && !in_valid_reg, "reset left an item pending")
    `CTT_ASSERT(a_miss_zero, m_valid && !m_hit |-> m_found_entry == '0 && m_found_level == '0, "miss result not zero")
    `CTT_ASSERT(a_hit_entry_ok, m_valid && m_hit |-> ctt_pkg::entry_ok(m_found_entry), "hit returned an invalid entry")
    `CTT_ASSERT(a_non_lookup_no_hit, advance && op_reg != ctt_pkg::OP_LOOKUP |=> !m_hit, "hit on a non-lookup item")

endmodule
